// ----- hw/rtl/h2r_pkg.sv -----
`timescale 1ns / 1ps

package h2r_pkg;

  // Fixed field widths of the pixel channels
  localparam int IN_W  = 14;
  localparam int OUT_W = 13;

  // Largest value an output field holds
  localparam int OUT_MAX = (1 << OUT_W) - 1;

  // Default fraction bits of the fixed-point format
  localparam int FRAC_BITS_DEF = 12;

  // Piece of the four-piece channel function
  typedef enum logic [1:0] {
    SEG_RISE = 2'd0,
    SEG_HI   = 2'd1,
    SEG_FALL = 2'd2,
    SEG_LO   = 2'd3
  } seg_t;

endpackage

// ----- hw/rtl/h2r_if.sv -----
`timescale 1ns / 1ps

// HSL pixel channel
interface h2r_in_if;
  import h2r_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] hue;
  logic signed [IN_W-1:0] saturation;
  logic signed [IN_W-1:0] lightness;

  modport source (output valid, output hue, output saturation, output lightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input lightness,
                  output ready);
endinterface

// RGB pixel channel
interface h2r_out_if;
  import h2r_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] red;
  logic [OUT_W-1:0] green;
  logic [OUT_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ----- hw/rtl/hsl_to_rgb_convert_core.sv -----
`timescale 1ns / 1ps

// HSL to RGB pixel converter. Takes one pixel per clock when not stalled (hue,
// saturation, lightness, signed Q1.FRAC_BITS) and returns red, green, blue in
// unsigned Q1.FRAC_BITS, full scale 1 << FRAC_BITS. A new pixel is accepted
// every cycle unless backpressure stalls the pipeline; each pixel passes a
// six-stage pipeline (clamp and hue offsets, l*s multiply, upper level, lower
// level and span, three channel multiplies, channel select and output
// register). Each stage holds while the stage after it is full and stalled, so
// bubbles are squeezed out under backpressure. Hue wraps modulo one turn,
// saturation and lightness clamp to [0, 1.0]; hue offsets use exact thirds of a turn.
module hsl_to_rgb_convert_core #(
  parameter int FRAC_BITS = h2r_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  h2r_in_if.sink    in_pix,
  h2r_out_if.source out_pix
);
  import h2r_pkg::*;

  localparam int UW     = FRAC_BITS + 1;                    // holds 0..ONE
  localparam int TW     = FRAC_BITS + 2;                    // holds 0..3*ONE-1
  localparam int PW     = 2 * UW;                           // product width
  localparam int CW     = (IN_W - 1 > UW) ? IN_W - 1 : UW;  // clamp compare width
  localparam int HW     = (IN_W > FRAC_BITS) ? IN_W : FRAC_BITS;
  localparam int ONE_I  = 1 << FRAC_BITS;
  localparam int HALF_I = ONE_I / 2;
  localparam int CAP_I  = (ONE_I > OUT_MAX) ? OUT_MAX : ONE_I;

  localparam logic [UW-1:0] ONE_V  = UW'(ONE_I);
  localparam logic [UW-1:0] HALF_V = UW'(HALF_I);

  // ---------------------------------------------------------------
  // Stage handshake: a stage loads when it is empty or drains
  // ---------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  assign rdy6 = !v6_r || out_pix.ready;
  assign rdy5 = !v5_r || rdy6;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_pix.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_pix.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: clamp s and l, wrap hue, form channel offsets in ONE/3
  // ---------------------------------------------------------------
  logic [UW-1:0]        s1_nxt, l1_nxt, s1_r, l1_r;
  logic [TW-1:0]        t1_nxt [3];
  logic [TW-1:0]        t1_r [3];
  logic signed [HW-1:0] h_ext;
  logic [FRAC_BITS-1:0] h_wrap;
  logic [TW-1:0]        h3;
  logic [TW-1:0]        tr_sum;
  logic [CW-1:0]        s_mag, l_mag;

  always_comb begin
    s_mag = CW'(in_pix.saturation[IN_W-2:0]);
    l_mag = CW'(in_pix.lightness[IN_W-2:0]);

    if (in_pix.saturation[IN_W-1]) begin
      s1_nxt = '0;
    end else if (s_mag > CW'(ONE_I)) begin
      s1_nxt = ONE_V;
    end else begin
      s1_nxt = UW'(s_mag);
    end

    if (in_pix.lightness[IN_W-1]) begin
      l1_nxt = '0;
    end else if (l_mag > CW'(ONE_I)) begin
      l1_nxt = ONE_V;
    end else begin
      l1_nxt = UW'(l_mag);
    end

    // hue modulo one turn, then times three
    h_ext  = HW'(in_pix.hue);
    h_wrap = h_ext[FRAC_BITS-1:0];
    h3     = TW'({2'b00, h_wrap}) + TW'({1'b0, h_wrap, 1'b0});

    // red: h + 1/3
    tr_sum = h3 + TW'(ONE_I);
    if (tr_sum >= TW'(3 * ONE_I)) begin
      t1_nxt[0] = tr_sum - TW'(3 * ONE_I);
    end else begin
      t1_nxt[0] = tr_sum;
    end
    // green: h
    t1_nxt[1] = h3;
    // blue: h - 1/3
    if (h3 < TW'(ONE_I)) begin
      t1_nxt[2] = h3 + TW'(2 * ONE_I);
    end else begin
      t1_nxt[2] = h3 - TW'(ONE_I);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_r <= s1_nxt;
      l1_r <= l1_nxt;
      for (int i = 0; i < 3; i++) t1_r[i] <= t1_nxt[i];
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: l*s product, channel piece and multiplier factor
  // ---------------------------------------------------------------
  logic [PW-1:0]   prod2_r;
  logic [UW-1:0]   s2_r, l2_r;
  seg_t            seg2_nxt [3];
  seg_t            seg2_r [3];
  logic [UW-1:0]   fac2_nxt [3];
  logic [UW-1:0]   fac2_r [3];
  logic [TW:0]     fall_f [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fall_f[i] = (TW + 1)'(4 * ONE_I) - {t1_r[i], 1'b0};
      if (t1_r[i] < TW'(HALF_I)) begin
        seg2_nxt[i] = SEG_RISE;
        fac2_nxt[i] = UW'({t1_r[i], 1'b0});
      end else if (t1_r[i] < TW'(3 * HALF_I)) begin
        seg2_nxt[i] = SEG_HI;
        fac2_nxt[i] = '0;
      end else if (t1_r[i] < TW'(2 * ONE_I)) begin
        seg2_nxt[i] = SEG_FALL;
        fac2_nxt[i] = UW'(fall_f[i]);
      end else begin
        seg2_nxt[i] = SEG_LO;
        fac2_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      prod2_r <= PW'(l1_r) * PW'(s1_r);
      s2_r    <= s1_r;
      l2_r    <= l1_r;
      for (int i = 0; i < 3; i++) begin
        seg2_r[i] <= seg2_nxt[i];
        fac2_r[i] <= fac2_nxt[i];
      end
    end
  end

  // ---------------------------------------------------------------
  // Stage 3: upper level hi, clamped to one
  // ---------------------------------------------------------------
  logic [PW:0]   prod_rnd;
  logic [UW-1:0] ls_r;
  logic [UW:0]   hi_raw;
  logic [UW-1:0] hi3_nxt, hi3_r, l3_r;
  seg_t          seg3_r [3];
  logic [UW-1:0] fac3_r [3];

  always_comb begin
    prod_rnd = {1'b0, prod2_r} + (PW + 1)'(HALF_I);
    ls_r     = prod_rnd[FRAC_BITS +: UW];
    if (l2_r < HALF_V) begin
      hi_raw = {1'b0, l2_r} + {1'b0, ls_r};
    end else begin
      hi_raw = {1'b0, l2_r} + {1'b0, s2_r} - {1'b0, ls_r};
    end
    if (hi_raw > (UW + 1)'(ONE_I)) begin
      hi3_nxt = ONE_V;
    end else begin
      hi3_nxt = hi_raw[UW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      hi3_r <= hi3_nxt;
      l3_r  <= l2_r;
      for (int i = 0; i < 3; i++) begin
        seg3_r[i] <= seg2_r[i];
        fac3_r[i] <= fac2_r[i];
      end
    end
  end

  // ---------------------------------------------------------------
  // Stage 4: lower level lo = 2l - hi, floored at zero, and span
  // ---------------------------------------------------------------
  logic signed [UW+1:0] lo_raw;
  logic [UW-1:0]        lo4_nxt, lo4_r, hi4_r, span4_r;
  seg_t                 seg4_r [3];
  logic [UW-1:0]        fac4_r [3];

  always_comb begin
    lo_raw = $signed({1'b0, l3_r, 1'b0}) - $signed({2'b00, hi3_r});
    if (lo_raw[UW+1]) begin
      lo4_nxt = '0;
    end else begin
      lo4_nxt = lo_raw[UW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      lo4_r   <= lo4_nxt;
      hi4_r   <= hi3_r;
      span4_r <= hi3_r - lo4_nxt;
      for (int i = 0; i < 3; i++) begin
        seg4_r[i] <= seg3_r[i];
        fac4_r[i] <= fac3_r[i];
      end
    end
  end

  // ---------------------------------------------------------------
  // Stage 5: span times factor, one multiplier per channel
  // ---------------------------------------------------------------
  logic [PW-1:0] mp5_r [3];
  logic [UW-1:0] lo5_r, hi5_r;
  seg_t          seg5_r [3];

  always_ff @(posedge clk) begin
    if (rdy5) begin
      lo5_r <= lo4_r;
      hi5_r <= hi4_r;
      for (int i = 0; i < 3; i++) begin
        mp5_r[i]  <= PW'(span4_r) * PW'(fac4_r[i]);
        seg5_r[i] <= seg4_r[i];
      end
    end
  end

  // ---------------------------------------------------------------
  // Stage 6: round, pick the piece, clamp, output register
  // ---------------------------------------------------------------
  logic [PW:0]      mp_rnd [3];
  logic [UW:0]      ch_v [3];
  logic [OUT_W-1:0] ch6_nxt [3];
  logic [OUT_W-1:0] ch6_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mp_rnd[i] = {1'b0, mp5_r[i]} + (PW + 1)'(HALF_I);
      case (seg5_r[i])
        SEG_RISE, SEG_FALL: ch_v[i] = {1'b0, lo5_r} + {1'b0, mp_rnd[i][FRAC_BITS +: UW]};
        SEG_HI:             ch_v[i] = {1'b0, hi5_r};
        SEG_LO:             ch_v[i] = {1'b0, lo5_r};
        default:            ch_v[i] = {1'b0, lo5_r};
      endcase
      if (ch_v[i] > (UW + 1)'(CAP_I)) begin
        ch6_nxt[i] = OUT_W'(CAP_I);
      end else begin
        ch6_nxt[i] = OUT_W'(ch_v[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      for (int i = 0; i < 3; i++) ch6_r[i] <= ch6_nxt[i];
    end
  end

  assign out_pix.valid = v6_r;
  assign out_pix.red   = ch6_r[0];
  assign out_pix.green = ch6_r[1];
  assign out_pix.blue  = ch6_r[2];

endmodule

// ----- tb/sv/hsl_to_rgb_convert_core_tb.sv -----
`timescale 1ns / 1ps

module hsl_to_rgb_convert_core_tb;
  import h2r_pkg::*;

  localparam int     FRAC     = FRAC_BITS_DEF;
  localparam longint UNIT     = longint'(1) << FRAC;
  localparam int     N_RANDOM = 1700;
  localparam int     HOLD_LEN = 400;

  typedef struct packed {
    logic signed [IN_W-1:0] hue;
    logic signed [IN_W-1:0] sat;
    logic signed [IN_W-1:0] light;
  } hsl_t;

  typedef struct packed {
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
  } rgb_t;

  typedef struct {
    hsl_t pix;
    bit   fixed;
    rgb_t rgb;
  } hsl_case_t;

  logic clk;
  logic rst_n;

  h2r_in_if  in_pix ();
  h2r_out_if out_pix ();

  hsl_to_rgb_convert_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix),
    .out_pix (out_pix)
  );

  // Expected pixels, oldest first
  rgb_t      rgb_due_q[$];
  hsl_case_t dir_tbl[$];

  // Typed expectation travels with the driven pixel
  bit   drv_fixed;
  rgb_t drv_rgb;

  int mismatches;
  int rgb_seen;

  // ---------------------------------------------------------------- predictor

  function automatic longint clamp_unit(longint v);
    if (v < 0) return 0;
    if (v > UNIT) return UNIT;
    return v;
  endfunction

  // product of two fixed-point values, round half up
  function automatic longint fx_mul(longint a, longint b);
    return (a * b + (UNIT >> 1)) >>> FRAC;
  endfunction

  // t3 is the channel hue in thirds of a unit, range [0, 3*UNIT)
  function automatic logic [OUT_W-1:0] channel_level(longint t3, longint hi, longint lo);
    seg_t   seg;
    longint lvl;
    if (2 * t3 < UNIT) seg = SEG_RISE;
    else if (2 * t3 < 3 * UNIT) seg = SEG_HI;
    else if (t3 < 2 * UNIT) seg = SEG_FALL;
    else seg = SEG_LO;
    case (seg)
      SEG_RISE: lvl = lo + fx_mul(hi - lo, 2 * t3);
      SEG_HI:   lvl = hi;
      SEG_FALL: lvl = lo + fx_mul(hi - lo, 4 * UNIT - 2 * t3);
      default:  lvl = lo;
    endcase
    lvl = clamp_unit(lvl);
    if (lvl > OUT_MAX) lvl = OUT_MAX;
    return lvl[OUT_W-1:0];
  endfunction

  function automatic rgb_t hsl_to_rgb_pred(hsl_t p);
    longint hue_w, sat_c, lit_c, hi, lo, h3, t_red, t_blue;
    rgb_t   res;
    hue_w = longint'($signed(p.hue)) & (UNIT - 1);
    sat_c = clamp_unit(longint'($signed(p.sat)));
    lit_c = clamp_unit(longint'($signed(p.light)));
    // grey when there is no saturation
    if (sat_c == 0) begin
      res.red   = channel_level(UNIT, lit_c, lit_c);
      res.green = res.red;
      res.blue  = res.red;
      return res;
    end
    if (lit_c < (UNIT >> 1)) hi = fx_mul(lit_c, sat_c) + lit_c;
    else hi = lit_c + sat_c - fx_mul(lit_c, sat_c);
    hi = clamp_unit(hi);
    lo = 2 * lit_c - hi;
    if (lo < 0) lo = 0;
    // hue offsets in exact thirds
    h3 = 3 * hue_w;
    t_red = h3 + UNIT;
    if (t_red >= 3 * UNIT) t_red -= 3 * UNIT;
    t_blue = h3 - UNIT;
    if (t_blue < 0) t_blue += 3 * UNIT;
    res.red   = channel_level(t_red, hi, lo);
    res.green = channel_level(h3, hi, lo);
    res.blue  = channel_level(t_blue, hi, lo);
    return res;
  endfunction

  // ---------------------------------------------------------------- helpers

  function automatic logic signed [IN_W-1:0] rand_field();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return IN_W'(int'($urandom_range(0, 2 * UNIT)) - int'(UNIT));
    if (r < 82) return IN_W'($urandom);
    case ($urandom_range(0, 8))
      0:       return IN_W'(-UNIT);
      1:       return IN_W'(0);
      2:       return IN_W'(UNIT);
      3:       return IN_W'(UNIT >> 1);
      4:       return IN_W'((UNIT >> 1) - 1);
      5:       return IN_W'(UNIT - 1);
      6:       return IN_W'(-1);
      7:       return IN_W'(1 << (IN_W - 1));
      default: return IN_W'((1 << (IN_W - 1)) - 1);
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_case(int h, int s, int l, bit fixed, int r, int g, int b);
    hsl_case_t c;
    c.pix.hue   = IN_W'(h);
    c.pix.sat   = IN_W'(s);
    c.pix.light = IN_W'(l);
    c.fixed     = fixed;
    c.rgb.red   = OUT_W'(r);
    c.rgb.green = OUT_W'(g);
    c.rgb.blue  = OUT_W'(b);
    dir_tbl.push_back(c);
  endtask

  // offer one pixel and hold it until the transfer
  task automatic send_pixel(hsl_t p, bit fixed, rgb_t rgb);
    in_pix.valid      <= 1'b1;
    in_pix.hue        <= p.hue;
    in_pix.saturation <= p.sat;
    in_pix.lightness  <= p.light;
    drv_fixed         <= fixed;
    drv_rgb           <= rgb;
    @(posedge clk);
    while (!in_pix.ready) @(posedge clk);
  endtask

  task automatic idle_after(int gap);
    if (gap > 0) begin
      in_pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_pixels();
    in_pix.valid <= 1'b0;
    @(posedge clk);
    while (rgb_due_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- clock

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- scoreboard

  always @(posedge clk) begin
    rgb_t got;
    rgb_t want;
    if (rst_n) begin
      // input transfer: record what must come out
      if (in_pix.valid && in_pix.ready) begin
        if (drv_fixed) rgb_due_q.push_back(drv_rgb);
        else rgb_due_q.push_back(hsl_to_rgb_pred({in_pix.hue, in_pix.saturation,
                                                  in_pix.lightness}));
      end
      // output transfer: compare with the oldest expectation
      if (out_pix.valid && out_pix.ready) begin
        got = {out_pix.red, out_pix.green, out_pix.blue};
        rgb_seen++;
        if (rgb_due_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected pixel r=%0d g=%0d b=%0d", $time,
                   got.red, got.green, got.blue);
        end else begin
          want = rgb_due_q.pop_front();
          if (got.red !== want.red) begin
            mismatches++;
            $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
          end
          if (got.green !== want.green) begin
            mismatches++;
            $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
          end
          if (got.blue !== want.blue) begin
            mismatches++;
            $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  initial begin
    bit long_hold_done;
    int stall;
    int run;
    long_hold_done = 1'b0;
    out_pix.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!long_hold_done && rgb_seen >= 400) begin
        // long backpressure so the pipeline fills and stalls its input
        long_hold_done = 1'b1;
        out_pix.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_pix.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_pix.ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 6);
      repeat (run) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    hsl_t p;
    rgb_t none;
    bit   no_gaps;
    mismatches = 0;
    rgb_seen   = 0;
    none       = '0;
    rst_n             <= 1'b0;
    in_pix.valid      <= 1'b0;
    in_pix.hue        <= '0;
    in_pix.saturation <= '0;
    in_pix.lightness  <= '0;
    drv_fixed         <= 1'b0;
    drv_rgb           <= '0;

    // grey, clamps and primaries have obvious results
    add_case(0, 0, 0, 1, 0, 0, 0);
    add_case(1234, 0, 4096, 1, 4096, 4096, 4096);
    add_case(-1, 0, 2048, 1, 2048, 2048, 2048);
    add_case(700, -4096, 1000, 1, 1000, 1000, 1000);
    add_case(3000, 4096, -4096, 1, 0, 0, 0);
    add_case(500, 4096, 4096, 1, 4096, 4096, 4096);
    add_case(0, 4096, 2048, 1, 4096, 0, 0);
    add_case(-4096, 4096, 2048, 1, 4096, 0, 0);
    add_case(4096, 4096, 2048, 1, 4096, 0, 0);
    add_case(-8192, 4096, 2048, 1, 4096, 0, 0);
    add_case(2000, 8191, 8191, 1, 4096, 4096, 4096);
    add_case(100, -8192, 8191, 1, 4096, 4096, 4096);
    // piece boundaries, lightness threshold and hue wrap
    add_case(683, 4096, 2048, 0, 0, 0, 0);
    add_case(1365, 3000, 2047, 0, 0, 0, 0);
    add_case(1366, 3000, 2048, 0, 0, 0, 0);
    add_case(2048, 1, 2048, 0, 0, 0, 0);
    add_case(2731, 2500, 1500, 0, 0, 0, 0);
    add_case(4095, 4096, 3000, 0, 0, 0, 0);
    add_case(8191, 1, 1, 0, 0, 0, 0);
    add_case(-1365, 2048, 3500, 0, 0, 0, 0);
    add_case(-2731, 4095, 4095, 0, 0, 0, 0);
    add_case(3413, 4096, 1, 0, 0, 0, 0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[i]) begin
      send_pixel(dir_tbl[i].pix, dir_tbl[i].fixed, dir_tbl[i].rgb);
      idle_after(pick_gap());
    end
    drain_pixels();

    no_gaps = 1'b0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (n == N_RANDOM / 2) drain_pixels();
      p.hue   = rand_field();
      p.sat   = rand_field();
      p.light = rand_field();
      send_pixel(p, 1'b0, none);
      if (!no_gaps) idle_after(pick_gap());
    end
    drain_pixels();

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // ---------------------------------------------------------------- watchdog

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
